[src/sda_pkg.sv]
// sda_pkg: shared types and constants of the DMA descriptor slot allocator.
// No dependencies; imported by sda_ctrl, the top level and the testbench.
`default_nettype none

package sda_pkg;

  localparam int CHANNELS_DEF    = 64;
  localparam int SLOTS_DEF       = 256;
  localparam int PER_CHANNEL_DEF = 32;
  localparam int SCAN_START_DEF  = 32;

  // slot bitmap word
  localparam int WORD_BITS  = 32;
  localparam int WORD_SHIFT = 5;

  typedef enum logic [2:0] {
    CMD_CLAIM    = 3'd0,
    CMD_RELEASE  = 3'd1,
    CMD_ALLOC    = 3'd2,
    CMD_FREE     = 3'd3,
    CMD_DISPATCH = 3'd4
  } cmd_e;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_BUSY  = 2'd1;
  localparam logic [1:0] ST_RANGE = 2'd2;
  localparam logic [1:0] ST_NONE  = 2'd3;

  localparam logic [1:0] CFG_MAP   = 2'd0;
  localparam logic [1:0] CFG_SLOTS = 2'd1;
  localparam logic [1:0] CFG_CHANS = 2'd2;

  typedef enum logic [3:0] {
    S_IDLE,
    S_CNT,
    S_AFIX,
    S_SCAN_RD,
    S_SCAN,
    S_FR0,
    S_FR1,
    S_FR2,
    S_DSEL,
    S_RESP
  } state_e;

  typedef struct packed {
    logic       has_map;
    logic [8:0] ns;
    logic [6:0] nc;
  } cfg_t;

endpackage

`default_nettype wire

[src/sda_ram.sv]
// sda_ram: single-port-write, single-port-read synchronous RAM, registered read.
// No dependencies.
`default_nettype none

module sda_ram #(
  parameter int W     = 8,
  parameter int DEPTH = 16,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic          clk_i,
  input  wire logic          wr_en_i,
  input  wire logic [AW-1:0] wr_addr_i,
  input  wire logic [W-1:0]  wr_data_i,
  input  wire logic          rd_en_i,
  input  wire logic [AW-1:0] rd_addr_i,
  output logic      [W-1:0]  rd_data_o
);

  logic [W-1:0] mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem[wr_addr_i] <= wr_data_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_data_o <= mem[rd_addr_i];
    end
  end

endmodule

`default_nettype wire

[src/sda_ctrl.sv]
// sda_ctrl: command sequencer; read-modify-write over the slot bitmap,
// owned-count and owned-list RAMs. Depends on sda_pkg and sda_ram.
`default_nettype none

module sda_ctrl #(
  parameter int CHANNELS    = sda_pkg::CHANNELS_DEF,
  parameter int SLOTS       = sda_pkg::SLOTS_DEF,
  parameter int PER_CHANNEL = sda_pkg::PER_CHANNEL_DEF,
  parameter int SCAN_START  = sda_pkg::SCAN_START_DEF
) (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire sda_pkg::cfg_t cfg_i,
  input  wire logic          in_valid_i,
  output logic               in_stall_o,
  input  wire logic [2:0]    cmd_i,
  input  wire logic [5:0]    channel_i,
  input  wire logic          trigger_slot_i,
  input  wire logic [63:0]   pending_mask_i,
  input  wire logic [63:0]   enable_mask_i,
  output logic               out_valid_o,
  input  wire logic          out_stall_i,
  output logic [1:0]         status_o,
  output logic [7:0]         slot_o,
  output logic [5:0]         notify_channel_o,
  output logic               last_o
);
  import sda_pkg::*;

  localparam int ROWS      = (SLOTS + WORD_BITS - 1) / WORD_BITS;
  localparam int RW        = (ROWS > 1) ? $clog2(ROWS) : 1;
  localparam int CW        = $clog2(CHANNELS);
  localparam int CNTW      = $clog2(PER_CHANNEL + 1);
  localparam int LDEPTH    = CHANNELS * PER_CHANNEL;
  localparam int LW        = $clog2(LDEPTH);
  localparam int START_ROW = SCAN_START / WORD_BITS;

  state_e state_q, state_d, ret_q, ret_d;
  logic [2:0]          cmd_q, cmd_d;
  logic [CW-1:0]       ch_q, ch_d;
  logic                trig_q, trig_d;
  logic                disp_q, disp_d;
  logic [CHANNELS-1:0] mask_q, mask_d, claimed_q, claimed_d;
  logic [RW-1:0]       row_q, row_d;
  logic [4:0]          sbit_q, sbit_d;
  logic [CNTW-1:0]     idx_q, idx_d, n_q, n_d;
  logic [1:0]          res_status_q, res_status_d;
  logic [7:0]          res_slot_q, res_slot_d;
  logic [5:0]          res_nc_q, res_nc_d;
  logic                res_last_q, res_last_d;
  logic                out_valid_q, out_valid_d;
  logic [1:0]          status_q, status_d;
  logic [7:0]          slot_q, slot_d;
  logic [5:0]          nc_q, nc_d;
  logic                last_q, last_d;

  // per-row / per-channel valid bits stand in for the RAM reset values
  logic [ROWS-1:0]     used_vld_q;
  logic [CHANNELS-1:0] cnt_vld_q;
  logic                used_rv_q, used_r0_q, cnt_rv_q;

  logic                used_rd_en, used_wr_en;
  logic [RW-1:0]       used_rd_row, used_wr_row;
  logic [WORD_BITS-1:0] used_raw, used_word, used_wr_data;
  logic                cnt_rd_en, cnt_wr_en;
  logic [CW-1:0]       cnt_rd_addr, cnt_wr_addr;
  logic [CNTW-1:0]     cnt_raw, cnt_val, cnt_wr_data;
  logic                list_rd_en, list_wr_en;
  logic [LW-1:0]       list_rd_addr, list_wr_addr;
  logic [7:0]          list_raw, list_wr_data;

  logic [CHANNELS-1:0] in_mask;
  logic                in_range, out_free;
  logic                cnt_full, fixed_mode, fix_oor, scan_none, fix_free;
  logic [4:0]          fix_bit, scan_bit;
  logic                scan_hit, scan_last;
  logic [9:0]          scan_slot;
  logic [RW:0]         row_nxt;
  logic [CW-1:0]       dsel_ch;

  sda_ram #(.W(WORD_BITS), .DEPTH(ROWS)) u_used (
    .clk_i, .wr_en_i(used_wr_en), .wr_addr_i(used_wr_row), .wr_data_i(used_wr_data),
    .rd_en_i(used_rd_en), .rd_addr_i(used_rd_row), .rd_data_o(used_raw)
  );

  sda_ram #(.W(CNTW), .DEPTH(CHANNELS)) u_cnt (
    .clk_i, .wr_en_i(cnt_wr_en), .wr_addr_i(cnt_wr_addr), .wr_data_i(cnt_wr_data),
    .rd_en_i(cnt_rd_en), .rd_addr_i(cnt_rd_addr), .rd_data_o(cnt_raw)
  );

  sda_ram #(.W(8), .DEPTH(LDEPTH)) u_list (
    .clk_i, .wr_en_i(list_wr_en), .wr_addr_i(list_wr_addr), .wr_data_i(list_wr_data),
    .rd_en_i(list_rd_en), .rd_addr_i(list_rd_addr), .rd_data_o(list_raw)
  );

  assign used_word = used_rv_q ? used_raw : (used_r0_q ? WORD_BITS'(1) : '0);
  assign cnt_val   = cnt_rv_q ? cnt_raw : '0;

  assign in_mask    = pending_mask_i[CHANNELS-1:0] & enable_mask_i[CHANNELS-1:0] & claimed_q;
  assign in_range   = {1'b0, channel_i} < cfg_i.nc;
  assign out_free   = !out_valid_q || !out_stall_i;
  assign cnt_full   = cnt_val >= CNTW'(PER_CHANNEL);
  assign fixed_mode = !cfg_i.has_map && trig_q;
  assign fix_oor    = 9'(ch_q) >= cfg_i.ns;
  assign scan_none  = 9'(SCAN_START) >= cfg_i.ns;
  assign fix_bit    = 5'(ch_q);
  assign fix_free   = !used_word[fix_bit];
  assign row_nxt    = {1'b0, row_q} + 1'b1;
  assign scan_last  = (10'(row_nxt) << WORD_SHIFT) >= {1'b0, cfg_i.ns} ||
                      row_q == RW'(ROWS - 1);

  always_comb begin
    logic [9:0] s;
    scan_hit = 1'b0;
    scan_bit = '0;
    for (int b = WORD_BITS - 1; b >= 0; b--) begin
      s = (10'(row_q) << WORD_SHIFT) | 10'(b);
      if (!used_word[b] && s >= 10'(SCAN_START) && s < {1'b0, cfg_i.ns}) begin
        scan_hit = 1'b1;
        scan_bit = 5'(b);
      end
    end
  end
  assign scan_slot = (10'(row_q) << WORD_SHIFT) | 10'(scan_bit);

  always_comb begin
    dsel_ch = '0;
    for (int i = CHANNELS - 1; i >= 0; i--) begin
      if (mask_q[i]) begin
        dsel_ch = CW'(i);
      end
    end
  end

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          case (cmd_i)
            CMD_DISPATCH: state_d = (in_mask == '0) ? S_RESP : S_DSEL;
            CMD_RELEASE, CMD_ALLOC, CMD_FREE: state_d = in_range ? S_CNT : S_RESP;
            default: state_d = S_RESP;
          endcase
        end
      end
      S_CNT: begin
        if (cmd_q == CMD_ALLOC) begin
          if (cnt_full) state_d = S_RESP;
          else if (fixed_mode) state_d = fix_oor ? S_RESP : S_AFIX;
          else state_d = scan_none ? S_RESP : S_SCAN_RD;
        end else begin
          state_d = S_FR0;
        end
      end
      S_AFIX:    state_d = S_RESP;
      S_SCAN_RD: state_d = S_SCAN;
      S_SCAN:    state_d = (scan_hit || scan_last) ? S_RESP : S_SCAN_RD;
      S_FR0:     state_d = (idx_q == n_q) ? S_RESP : S_FR1;
      S_FR1:     state_d = S_FR2;
      S_FR2:     state_d = S_FR0;
      S_DSEL:    state_d = S_CNT;
      S_RESP:    state_d = out_free ? ret_q : S_RESP;
      default:   state_d = S_IDLE;
    endcase
  end

  // datapath and RAM controls
  always_comb begin
    cmd_d = cmd_q; ch_d = ch_q; trig_d = trig_q; disp_d = disp_q;
    mask_d = mask_q; claimed_d = claimed_q; row_d = row_q; sbit_d = sbit_q;
    idx_d = idx_q; n_d = n_q; ret_d = ret_q;
    res_status_d = res_status_q; res_slot_d = res_slot_q;
    res_nc_d = res_nc_q; res_last_d = res_last_q;
    out_valid_d = out_valid_q && out_stall_i;
    status_d = status_q; slot_d = slot_q; nc_d = nc_q; last_d = last_q;
    used_rd_en = 1'b0; used_rd_row = row_q;
    used_wr_en = 1'b0; used_wr_row = row_q; used_wr_data = used_word;
    cnt_rd_en = 1'b0; cnt_rd_addr = ch_q;
    cnt_wr_en = 1'b0; cnt_wr_addr = ch_q; cnt_wr_data = n_q + 1'b1;
    list_rd_en = 1'b0; list_rd_addr = LW'(int'(ch_q) * PER_CHANNEL + int'(idx_q));
    list_wr_en = 1'b0; list_wr_addr = LW'(int'(ch_q) * PER_CHANNEL + int'(n_q));
    list_wr_data = 8'(ch_q);
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_d = cmd_i; ch_d = channel_i[CW-1:0]; trig_d = trigger_slot_i;
          mask_d = in_mask; disp_d = 1'b0; ret_d = S_IDLE;
          res_status_d = ST_OK; res_slot_d = '0; res_nc_d = '0; res_last_d = 1'b1;
          case (cmd_i)
            CMD_DISPATCH: begin
              if (in_mask == '0) res_status_d = ST_NONE;
            end
            CMD_CLAIM: begin
              if (!in_range) res_status_d = ST_RANGE;
              else if (claimed_q[channel_i[CW-1:0]]) res_status_d = ST_BUSY;
              else claimed_d[channel_i[CW-1:0]] = 1'b1;
            end
            CMD_RELEASE, CMD_ALLOC, CMD_FREE: begin
              if (!in_range) begin
                res_status_d = ST_RANGE;
              end else begin
                cnt_rd_en = 1'b1;
                cnt_rd_addr = channel_i[CW-1:0];
              end
            end
            default: res_status_d = ST_BUSY;
          endcase
        end
      end
      S_CNT: begin
        n_d = cnt_val;
        idx_d = '0;
        if (cmd_q == CMD_ALLOC) begin
          if (cnt_full) begin
            res_status_d = ST_BUSY;
          end else if (fixed_mode) begin
            if (fix_oor) begin
              res_status_d = ST_BUSY;
            end else begin
              row_d = RW'(ch_q >> WORD_SHIFT);
              used_rd_en = 1'b1;
              used_rd_row = RW'(ch_q >> WORD_SHIFT);
            end
          end else if (scan_none) begin
            res_status_d = ST_BUSY;
          end else begin
            row_d = RW'(START_ROW);
          end
        end
      end
      S_AFIX: begin
        if (fix_free) begin
          used_wr_en = 1'b1;
          used_wr_data = used_word | (WORD_BITS'(1) << fix_bit);
          list_wr_en = 1'b1;
          cnt_wr_en = 1'b1;
          res_slot_d = 8'(ch_q);
        end else begin
          res_status_d = ST_BUSY;
        end
      end
      S_SCAN_RD: used_rd_en = 1'b1;
      S_SCAN: begin
        if (scan_hit) begin
          used_wr_en = 1'b1;
          used_wr_data = used_word | (WORD_BITS'(1) << scan_bit);
          list_wr_en = 1'b1;
          list_wr_data = 8'(scan_slot);
          cnt_wr_en = 1'b1;
          res_slot_d = 8'(scan_slot);
        end else if (scan_last) begin
          res_status_d = ST_BUSY;
        end else begin
          row_d = row_nxt[RW-1:0];
        end
      end
      S_FR0: begin
        if (idx_q == n_q) begin
          cnt_wr_en = 1'b1;
          cnt_wr_data = '0;
          res_status_d = ST_OK; res_slot_d = '0;
          if (disp_q) begin
            res_nc_d = 6'(ch_q);
            res_last_d = (mask_q == '0);
            ret_d = (mask_q == '0) ? S_IDLE : S_DSEL;
          end else if (cmd_q == CMD_RELEASE) begin
            claimed_d[ch_q] = 1'b0;
          end
        end else begin
          list_rd_en = 1'b1;
        end
      end
      S_FR1: begin
        sbit_d = list_raw[4:0];
        row_d = RW'(list_raw >> WORD_SHIFT);
        used_rd_en = 1'b1;
        used_rd_row = RW'(list_raw >> WORD_SHIFT);
      end
      S_FR2: begin
        used_wr_en = 1'b1;
        used_wr_data = used_word & ~(WORD_BITS'(1) << sbit_q);
        idx_d = idx_q + 1'b1;
      end
      S_DSEL: begin
        ch_d = dsel_ch;
        mask_d = mask_q & ~(CHANNELS'(1) << dsel_ch);
        disp_d = 1'b1;
        cnt_rd_en = 1'b1;
        cnt_rd_addr = dsel_ch;
      end
      S_RESP: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          status_d = res_status_q; slot_d = res_slot_q;
          nc_d = res_nc_q; last_d = res_last_q;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      ret_q       <= S_IDLE;
      claimed_q   <= '0;
      out_valid_q <= 1'b0;
      used_vld_q  <= '0;
      cnt_vld_q   <= '0;
    end else begin
      state_q     <= state_d;
      ret_q       <= ret_d;
      claimed_q   <= claimed_d;
      out_valid_q <= out_valid_d;
      if (used_wr_en) used_vld_q[used_wr_row] <= 1'b1;
      if (cnt_wr_en) cnt_vld_q[cnt_wr_addr] <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    cmd_q <= cmd_d; ch_q <= ch_d; trig_q <= trig_d; disp_q <= disp_d;
    mask_q <= mask_d; row_q <= row_d; sbit_q <= sbit_d;
    idx_q <= idx_d; n_q <= n_d;
    res_status_q <= res_status_d; res_slot_q <= res_slot_d;
    res_nc_q <= res_nc_d; res_last_q <= res_last_d;
    status_q <= status_d; slot_q <= slot_d; nc_q <= nc_d; last_q <= last_d;
    if (used_rd_en) begin
      used_rv_q <= used_vld_q[used_rd_row];
      used_r0_q <= (used_rd_row == '0);
    end
    if (cnt_rd_en) cnt_rv_q <= cnt_vld_q[cnt_rd_addr];
  end

  assign in_stall_o       = (state_q != S_IDLE);
  assign out_valid_o      = out_valid_q;
  assign status_o         = status_q;
  assign slot_o           = slot_q;
  assign notify_channel_o = nc_q;
  assign last_o           = last_q;

endmodule

`default_nettype wire

[src/dma_descriptor_slot_allocator.sv]
// Channel   | Direction | Handshake              | Payload
// in        | input     | in_valid_i/in_stall_o  | cmd, channel, trigger_slot, masks
// out       | output    | out_valid_o/out_stall_i| status, slot, notify_channel, last
// cfg       | input     | cfg_we_i               | cfg_idx_i, cfg_data_i
// One item at a time. Claim: result only. Allocate: count read, then fixed-slot RMW
// or a bitmap scan row by row. Free/release: count read, then list read and bitmap
// RMW per owned slot. Dispatch: a select per notified channel, then as free.
// Reset needs no clearing pass; valid bits cover the bitmap and count RAMs.
// A stalled result holds the sequencer in its result state.
// Top level: configuration registers; depends on sda_pkg, sda_ctrl, sda_ram.
`default_nettype none

module dma_descriptor_slot_allocator #(
  parameter int CHANNELS    = sda_pkg::CHANNELS_DEF,
  parameter int SLOTS       = sda_pkg::SLOTS_DEF,
  parameter int PER_CHANNEL = sda_pkg::PER_CHANNEL_DEF,
  parameter int SCAN_START  = sda_pkg::SCAN_START_DEF
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        cfg_we_i,
  input  wire logic [1:0]  cfg_idx_i,
  input  wire logic [8:0]  cfg_data_i,
  input  wire logic        in_valid_i,
  output logic             in_stall_o,
  input  wire logic [2:0]  cmd_i,
  input  wire logic [5:0]  channel_i,
  input  wire logic        trigger_slot_i,
  input  wire logic [63:0] pending_mask_i,
  input  wire logic [63:0] enable_mask_i,
  output logic             out_valid_o,
  input  wire logic        out_stall_i,
  output logic [1:0]       status_o,
  output logic [7:0]       slot_o,
  output logic [5:0]       notify_channel_o,
  output logic             last_o
);
  import sda_pkg::*;

  logic       map_q;
  logic [8:0] scount_q;
  logic [6:0] ccount_q;
  cfg_t       cfg;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      map_q    <= 1'b0;
      scount_q <= 9'd256;
      ccount_q <= 7'd64;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_MAP:   map_q    <= cfg_data_i[0];
        CFG_SLOTS: scount_q <= cfg_data_i;
        CFG_CHANS: ccount_q <= cfg_data_i[6:0];
        default: ;
      endcase
    end
  end

  assign cfg.has_map = map_q;
  assign cfg.ns = (scount_q > 9'(SLOTS)) ? 9'(SLOTS) : scount_q;
  assign cfg.nc = (ccount_q > 7'(CHANNELS)) ? 7'(CHANNELS) : ccount_q;

  sda_ctrl #(
    .CHANNELS(CHANNELS), .SLOTS(SLOTS), .PER_CHANNEL(PER_CHANNEL), .SCAN_START(SCAN_START)
  ) u_ctrl (
    .clk_i, .rst_ni, .cfg_i(cfg),
    .in_valid_i, .in_stall_o, .cmd_i, .channel_i, .trigger_slot_i,
    .pending_mask_i, .enable_mask_i,
    .out_valid_o, .out_stall_i, .status_o, .slot_o, .notify_channel_o, .last_o
  );

`ifndef NO_ASSERTIONS
  a_take_blocks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o) else $error("accepted item did not block");
  a_none_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && status_o == ST_NONE |-> last_o) else $error("empty dispatch not last");
  a_err_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && status_o != ST_OK |-> slot_o == '0 && notify_channel_o == '0)
    else $error("failed result carries payload");
`endif

endmodule

`default_nettype wire

[bench/testbench.sv]
// Testbench for dma_descriptor_slot_allocator: directed and random command streams,
// a bitmap predictor of channel and slot ownership, field-by-field result checks.
// Depends on sda_pkg and the allocator RTL.
`timescale 1ns / 100ps

module testbench;
  import sda_pkg::*;

  typedef struct packed {
    logic [1:0] status;
    logic [7:0] slot;
    logic [5:0] notify_channel;
    logic       last;
  } result_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        cfg_we_i = 1'b0;
  logic [1:0]  cfg_idx_i = '0;
  logic [8:0]  cfg_data_i = '0;
  logic        in_valid_i = 1'b0;
  logic        in_stall_o;
  logic [2:0]  cmd_i = '0;
  logic [5:0]  channel_i = '0;
  logic        trigger_slot_i = 1'b0;
  logic [63:0] pending_mask_i = '0;
  logic [63:0] enable_mask_i = '0;
  logic        out_valid_o;
  logic        out_stall_i = 1'b0;
  logic [1:0]  status_o;
  logic [7:0]  slot_o;
  logic [5:0]  notify_channel_o;
  logic        last_o;

  dma_descriptor_slot_allocator dut (.*);

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  // allocator mirror
  logic       map_en;
  logic [8:0] nslots;
  logic [6:0] nchans;
  logic       used [256];
  logic       claimed [64];
  int         owned_n [64];
  logic [7:0] owned [64][32];

  result_t expected_q [$];
  int      mismatches = 0;
  int      results_seen = 0;
  int      items_sent = 0;
  int      cycles = 0;
  int      burst_left = 0;
  logic    stall_on = 1'b0;

  function automatic int slot_limit();
    return (nslots > 256) ? 256 : int'(nslots);
  endfunction

  function automatic int chan_limit();
    return (nchans > 64) ? 64 : int'(nchans);
  endfunction

  function automatic void release_slots(int ch);
    for (int i = 0; i < owned_n[ch]; i++) used[owned[ch][i]] = 1'b0;
    owned_n[ch] = 0;
  endfunction

  function automatic void push_result(logic [1:0] st, logic [7:0] sl, logic [5:0] nc,
                                      logic lst);
    result_t r;
    r.status = st;
    r.slot = sl;
    r.notify_channel = nc;
    r.last = lst;
    expected_q.push_back(r);
  endfunction

  function automatic void predict_command(logic [2:0] cmd, logic [5:0] ch, logic trig,
                                          logic [63:0] pend, logic [63:0] ena);
    int hits [$];
    int s;
    int ns;
    logic found;
    if (cmd == CMD_DISPATCH) begin
      for (int c = 0; c < 64; c++)
        if (pend[c] && ena[c] && claimed[c]) hits.push_back(c);
      if (hits.size() == 0) begin
        push_result(ST_NONE, 8'd0, 6'd0, 1'b1);
        return;
      end
      foreach (hits[i]) begin
        release_slots(hits[i]);
        push_result(ST_OK, 8'd0, 6'(hits[i]), i == hits.size() - 1);
      end
      return;
    end
    if (cmd > CMD_DISPATCH) begin
      push_result(ST_BUSY, 8'd0, 6'd0, 1'b1);
      return;
    end
    if (int'(ch) >= chan_limit()) begin
      push_result(ST_RANGE, 8'd0, 6'd0, 1'b1);
      return;
    end
    case (cmd)
      CMD_CLAIM: begin
        if (claimed[ch]) push_result(ST_BUSY, 8'd0, 6'd0, 1'b1);
        else begin
          claimed[ch] = 1'b1;
          push_result(ST_OK, 8'd0, 6'd0, 1'b1);
        end
      end
      CMD_RELEASE: begin
        release_slots(ch);
        claimed[ch] = 1'b0;
        push_result(ST_OK, 8'd0, 6'd0, 1'b1);
      end
      CMD_ALLOC: begin
        ns = slot_limit();
        found = 1'b0;
        s = 0;
        if (owned_n[ch] < 32) begin
          if (!map_en && trig) begin
            s = ch;
            found = (s < ns) && !used[s];
          end else begin
            for (s = 32; s < ns; s++)
              if (!used[s]) begin
                found = 1'b1;
                break;
              end
          end
        end
        if (found) begin
          used[s] = 1'b1;
          owned[ch][owned_n[ch]] = 8'(s);
          owned_n[ch]++;
          push_result(ST_OK, 8'(s), 6'd0, 1'b1);
        end else push_result(ST_BUSY, 8'd0, 6'd0, 1'b1);
      end
      default: begin
        release_slots(ch);
        push_result(ST_OK, 8'd0, 6'd0, 1'b1);
      end
    endcase
  endfunction

  // result checker and receiver stall pattern
  always @(posedge clk_i) begin
    result_t exp_r;
    cycles <= cycles + 1;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      results_seen <= results_seen + 1;
      if (expected_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result: status %0d slot %0d", status_o,
                                       slot_o);
      end else begin
        exp_r = expected_q.pop_front();
        if (status_o !== exp_r.status || slot_o !== exp_r.slot ||
            notify_channel_o !== exp_r.notify_channel || last_o !== exp_r.last) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: exp st %0d slot %0d nch %0d last %0d, got %0d %0d %0d %0d",
                     exp_r.status, exp_r.slot, exp_r.notify_channel, exp_r.last,
                     status_o, slot_o, notify_channel_o, last_o);
        end
      end
    end
  end

  always @(negedge clk_i) begin
    if ((cycles % 400) < 120) out_stall_i <= 1'b0;
    else if ((cycles % 400) < 250) out_stall_i <= ($urandom_range(0, 3) == 0);
    else out_stall_i <= ($urandom_range(0, 1) == 0);
  end

  always @(posedge clk_i) begin
    if (cycles > 2000000) begin
      $display("timeout after %0d cycles", cycles);
      $display("end of test: mismatches");
      $finish;
    end
  end

  task automatic send_command(logic [2:0] cmd, logic [5:0] ch, logic trig,
                              logic [63:0] pend, logic [63:0] ena);
    int gap;
    if (burst_left == 0) begin
      gap = $urandom_range(0, 1) ? 0 : $urandom_range(1, 12);
      if (gap != 0) begin
        in_valid_i <= 1'b0;
        repeat (gap) @(negedge clk_i);
      end
      burst_left = $urandom_range(1, 10);
    end
    burst_left--;
    in_valid_i <= 1'b1;
    cmd_i <= cmd;
    channel_i <= ch;
    trigger_slot_i <= trig;
    pending_mask_i <= pend;
    enable_mask_i <= ena;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    predict_command(cmd, ch, trig, pend, ena);
    items_sent++;
    @(negedge clk_i);
  endtask

  task automatic drain_results();
    in_valid_i <= 1'b0;
    while (expected_q.size() != 0) @(negedge clk_i);
    repeat (300) @(negedge clk_i);
  endtask

  task automatic write_register(logic [1:0] idx, logic [8:0] value);
    drain_results();
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= value;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    if (idx == CFG_MAP) map_en = value[0];
    else if (idx == CFG_SLOTS) nslots = value;
    else if (idx == CFG_CHANS) nchans = value[6:0];
  endtask

  function automatic logic [63:0] rand64();
    return {$urandom(), $urandom()};
  endfunction

  task automatic test_directed();
    send_command(CMD_DISPATCH, 6'd0, 1'b0, '1, '1);
    send_command(CMD_ALLOC, 6'd0, 1'b1, '0, '0);
    send_command(CMD_CLAIM, 6'd0, 1'b0, '0, '0);
    send_command(CMD_CLAIM, 6'd0, 1'b0, '0, '0);
    send_command(CMD_CLAIM, 6'd63, 1'b0, '0, '0);
    send_command(CMD_ALLOC, 6'd5, 1'b1, '0, '0);
    send_command(CMD_ALLOC, 6'd5, 1'b1, '0, '0);
    send_command(CMD_ALLOC, 6'd63, 1'b0, '0, '0);
    send_command(CMD_ALLOC, 6'd63, 1'b1, '0, '0);
    send_command(CMD_FREE, 6'd5, 1'b0, '0, '0);
    send_command(CMD_RELEASE, 6'd9, 1'b0, '0, '0);
    send_command(3'd5, 6'd1, 1'b0, '0, '0);
    send_command(3'd7, 6'd63, 1'b1, '1, '1);
    send_command(CMD_DISPATCH, 6'd0, 1'b0, '1, '0);
    send_command(CMD_DISPATCH, 6'd0, 1'b0, '1, '1);
    send_command(CMD_RELEASE, 6'd63, 1'b0, '0, '0);
  endtask

  task automatic test_channel_limit();
    for (int i = 0; i < 34; i++) send_command(CMD_ALLOC, 6'd2, 1'b0, '0, '0);
    send_command(CMD_RELEASE, 6'd2, 1'b0, '0, '0);
  endtask

  task automatic test_scan_exhaust();
    write_register(CFG_SLOTS, 9'd40);
    write_register(CFG_CHANS, 9'd2);
    for (int i = 0; i < 10; i++) send_command(CMD_ALLOC, 6'(i % 3), 1'b0, '0, '0);
    send_command(CMD_ALLOC, 6'd1, 1'b1, '0, '0);
    send_command(CMD_CLAIM, 6'd1, 1'b0, '0, '0);
    send_command(CMD_DISPATCH, 6'd0, 1'b0, '1, 64'h2);
    send_command(CMD_FREE, 6'd0, 1'b0, '0, '0);
    write_register(CFG_SLOTS, 9'd511);
    write_register(CFG_CHANS, 9'd127);
  endtask

  task automatic test_random(int count, logic map_value);
    int pick;
    logic [5:0] ch;
    write_register(CFG_MAP, {8'd0, map_value});
    for (int i = 0; i < count; i++) begin
      pick = $urandom_range(0, 99);
      ch = ($urandom_range(0, 3) == 0) ? 6'($urandom()) : 6'($urandom_range(0, 11));
      if (pick < 15) send_command(CMD_CLAIM, ch, 1'($urandom()), rand64(), rand64());
      else if (pick < 22)
        send_command(CMD_RELEASE, ch, 1'($urandom()), rand64(), rand64());
      else if (pick < 70) send_command(CMD_ALLOC, ch, 1'($urandom()), rand64(), rand64());
      else if (pick < 78) send_command(CMD_FREE, ch, 1'($urandom()), rand64(), rand64());
      else if (pick < 96)
        send_command(CMD_DISPATCH, ch, 1'($urandom()), rand64(),
                     $urandom_range(0, 1) ? '1 : rand64());
      else send_command(3'($urandom_range(5, 7)), ch, 1'($urandom()), rand64(), rand64());
      if (i == count / 2) drain_results();
    end
  endtask

  initial begin
    map_en = 1'b0;
    nslots = 9'd256;
    nchans = 7'd64;
    foreach (used[i]) used[i] = (i == 0);
    foreach (claimed[i]) begin
      claimed[i] = 1'b0;
      owned_n[i] = 0;
    end
    repeat (3) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);
    test_directed();
    test_channel_limit();
    test_scan_exhaust();
    test_random(130, 1'b0);
    test_random(130, 1'b1);
    write_register(CFG_SLOTS, 9'd16);
    write_register(CFG_CHANS, 9'd64);
    test_random(70, 1'b0);
    write_register(CFG_SLOTS, 9'd100);
    write_register(CFG_CHANS, 9'd33);
    test_random(55, 1'b1);
    drain_results();
    $display("covered %0d commands and %0d results over several slot/channel settings",
             items_sent, results_seen);
    if (mismatches == 0) $display("end of test: clean");
    else begin
      $display("%0d mismatches", mismatches);
      $display("end of test: mismatches");
    end
    $finish;
  end
endmodule
